[design/dfu_ctl_pkg.sv]
// Shared types and codes for the DFU control request block.
// Used by dfu_ctl_fsm and dfu_control_request_fsm; depends on nothing.
package dfu_ctl_pkg;

    // default width of the download block counter
    localparam int BLOCK_COUNT_BITS_DEF = 16;

    // configuration port
    localparam int                        CFG_INDEX_BITS   = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WILL_DETACH  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAN_DOWNLOAD = 8'd1;

    // DFU class request codes
    localparam logic [7:0] RQ_DETACH    = 8'd0;
    localparam logic [7:0] RQ_DNLOAD    = 8'd1;
    localparam logic [7:0] RQ_GETSTATUS = 8'd3;
    localparam logic [7:0] RQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] RQ_GETSTATE  = 8'd5;
    localparam logic [7:0] RQ_ABORT     = 8'd6;

    // media write status
    localparam logic [1:0] MEDIA_OK    = 2'd0;
    localparam logic [1:0] MEDIA_BUSY  = 2'd1;
    localparam logic [1:0] MEDIA_ERROR = 2'd2;

    // response kinds
    localparam logic [2:0] RK_ACK     = 3'd0;
    localparam logic [2:0] RK_STALL   = 3'd1;
    localparam logic [2:0] RK_STATUS  = 3'd2;
    localparam logic [2:0] RK_STATE   = 3'd3;
    localparam logic [2:0] RK_UNKNOWN = 3'd4;

    // notification kinds
    localparam logic [1:0] NT_NONE  = 2'd0;
    localparam logic [1:0] NT_BEGIN = 2'd1;
    localparam logic [1:0] NT_END   = 2'd2;
    localparam logic [1:0] NT_ABORT = 2'd3;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_WRITE_ERR = 1'b1;

    // one request
    typedef struct packed {
        logic [7:0]  cmd;
        logic [15:0] req_length;
        logic [1:0]  media_state;
    } t_req;

    // one response
    typedef struct packed {
        logic [2:0]  resp_kind;
        logic        status_code;
        logic [3:0]  state_report;
        logic        event_detach;
        logic        event_wait_reset;
        logic [1:0]  notify_kind;
        logic        write_strobe;
        logic [15:0] write_block_number;
        logic [15:0] write_length;
    } t_resp;

    // configuration register values
    typedef struct packed {
        logic will_detach;
        logic can_download;
    } t_cfg;

endpackage

[design/dfu_ctl_fsm.sv]
// DFU state machine: decodes one request against the current DFU state and
// registers the response. Depends on dfu_ctl_pkg.
module dfu_ctl_fsm #(
    parameter int BLOCK_COUNT_BITS = dfu_ctl_pkg::BLOCK_COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  dfu_ctl_pkg::t_req  i_req,
    input  dfu_ctl_pkg::t_cfg  i_cfg,
    output dfu_ctl_pkg::t_resp o_resp
);

    // DFU state numbering
    typedef enum logic [3:0] {
        ST_APP_IDLE            = 4'd0,
        ST_APP_DETACH          = 4'd1,
        ST_DFU_IDLE            = 4'd2,
        ST_DNLOAD_SYNC         = 4'd3,
        ST_DNBUSY              = 4'd4,
        ST_DNLOAD_IDLE         = 4'd5,
        ST_MANIFEST_SYNC       = 4'd6,
        ST_MANIFEST            = 4'd7,
        ST_MANIFEST_WAIT_RESET = 4'd8,
        ST_UPLOAD_IDLE         = 4'd9,
        ST_ERROR               = 4'd10
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_status, n_status;
    logic [BLOCK_COUNT_BITS-1:0] r_count, n_count;
    dfu_ctl_pkg::t_resp          r_resp, n_resp;

    // decode the request
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_count  = r_count;
        n_resp   = '0;
        case (r_state)
            ST_APP_IDLE: begin
                if (i_req.cmd == dfu_ctl_pkg::RQ_DETACH) begin
                    n_resp.resp_kind        = dfu_ctl_pkg::RK_ACK;
                    n_resp.event_detach     = i_cfg.will_detach;
                    n_resp.event_wait_reset = !i_cfg.will_detach;
                    n_state                 = ST_APP_DETACH;
                end else if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATUS) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATUS;
                end else if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATE) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATE;
                end else begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STALL;
                end
            end
            ST_APP_DETACH, ST_MANIFEST_SYNC: begin
                if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATUS) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATUS;
                    if (r_state == ST_MANIFEST_SYNC) begin
                        case (i_req.media_state)
                            dfu_ctl_pkg::MEDIA_OK: begin
                                n_status            = dfu_ctl_pkg::STATUS_OK;
                                n_state             = ST_MANIFEST_WAIT_RESET;
                                n_resp.event_detach = i_cfg.will_detach;
                            end
                            dfu_ctl_pkg::MEDIA_BUSY: begin
                                n_status = dfu_ctl_pkg::STATUS_OK;
                                n_state  = ST_MANIFEST;
                            end
                            dfu_ctl_pkg::MEDIA_ERROR: begin
                                n_status = dfu_ctl_pkg::STATUS_WRITE_ERR;
                                n_state  = ST_ERROR;
                            end
                            default: begin
                                n_status = r_status;
                            end
                        endcase
                    end
                end else if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATE) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATE;
                end else begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STALL;
                end
            end
            ST_DFU_IDLE, ST_DNLOAD_IDLE: begin
                if (i_req.cmd == dfu_ctl_pkg::RQ_DNLOAD) begin
                    if (r_state == ST_DFU_IDLE &&
                        (i_req.req_length == 16'd0 || !i_cfg.can_download)) begin
                        n_resp.resp_kind = dfu_ctl_pkg::RK_STALL;
                        n_state          = ST_ERROR;
                    end else if (i_req.req_length == 16'd0) begin
                        // empty block ends the download
                        n_resp.resp_kind   = dfu_ctl_pkg::RK_ACK;
                        n_resp.notify_kind = dfu_ctl_pkg::NT_END;
                        n_state            = ST_MANIFEST_SYNC;
                    end else begin
                        // issue the block write and advance the counter
                        n_resp.resp_kind          = dfu_ctl_pkg::RK_ACK;
                        n_resp.notify_kind        = (r_state == ST_DFU_IDLE) ?
                                                    dfu_ctl_pkg::NT_BEGIN :
                                                    dfu_ctl_pkg::NT_NONE;
                        n_resp.write_strobe       = 1'b1;
                        n_resp.write_block_number = 16'(r_count);
                        n_resp.write_length       = i_req.req_length;
                        n_count                   = BLOCK_COUNT_BITS'(r_count + 1'b1);
                        n_state                   = ST_DNLOAD_SYNC;
                    end
                end else if (i_req.cmd == dfu_ctl_pkg::RQ_ABORT) begin
                    n_resp.resp_kind   = dfu_ctl_pkg::RK_ACK;
                    n_resp.notify_kind = dfu_ctl_pkg::NT_ABORT;
                    n_state            = ST_DFU_IDLE;
                    n_count            = '0;
                end else if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATUS) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATUS;
                end else if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATE) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATE;
                end else begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STALL;
                    n_state          = ST_ERROR;
                end
            end
            ST_DNLOAD_SYNC: begin
                if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATUS) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATUS;
                    case (i_req.media_state)
                        dfu_ctl_pkg::MEDIA_OK: begin
                            n_status = dfu_ctl_pkg::STATUS_OK;
                            n_state  = ST_DNLOAD_IDLE;
                        end
                        dfu_ctl_pkg::MEDIA_BUSY: begin
                            n_status = dfu_ctl_pkg::STATUS_OK;
                            n_state  = ST_DNBUSY;
                        end
                        dfu_ctl_pkg::MEDIA_ERROR: begin
                            n_status = dfu_ctl_pkg::STATUS_WRITE_ERR;
                            n_state  = ST_ERROR;
                        end
                        default: begin
                            n_status = r_status;
                        end
                    endcase
                end else if (i_req.cmd == dfu_ctl_pkg::RQ_GETSTATE) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STATE;
                end else begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STALL;
                    n_state          = ST_ERROR;
                end
            end
            ST_ERROR: begin
                if (i_req.cmd == dfu_ctl_pkg::RQ_CLRSTATUS) begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_ACK;
                    n_state          = ST_DFU_IDLE;
                end else begin
                    n_resp.resp_kind = dfu_ctl_pkg::RK_STALL;
                end
            end
            default: begin
                // busy, manifest, wait-reset, upload and undefined states
                n_resp.resp_kind = dfu_ctl_pkg::RK_UNKNOWN;
            end
        endcase

        // reports carry the state and status after any media update
        if (n_resp.resp_kind == dfu_ctl_pkg::RK_STATUS) begin
            n_resp.status_code  = n_status;
            n_resp.state_report = n_state;
        end else if (n_resp.resp_kind == dfu_ctl_pkg::RK_STATE) begin
            n_resp.state_report = n_state;
        end
    end

    // hold state and the registered response; advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_APP_IDLE;
            r_status <= dfu_ctl_pkg::STATUS_OK;
            r_count  <= '0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_status <= n_status;
            r_count  <= n_count;
            r_resp   <= n_resp;
        end
    end

    assign o_resp = r_resp;

endmodule

[design/dfu_control_request_fsm.sv]
// Top level of the DFU control request block: input register, handshake
// control, configuration registers. Depends on dfu_ctl_pkg, dfu_ctl_fsm.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in_data) carries one DFU
//   class request per transfer: code, wLength and media write status.
//   Response channel (o_out_valid / i_out_stall / o_out_data) returns
//   exactly one response per request, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) writes will_detach (index 0) or can_download (index 1);
//   other indexes are ignored. Write it only while no request is in flight.
// Order: a request transfer fills the input register, the state machine
//   then decides it into its registered response, which is offered.
// Throughput: one request per cycle unless i_out_stall holds a response;
//   the state machine decides each request from the current DFU state.
// Reset (i_rst_n low, synchronous): DFU state appIDLE, status ok, block
//   counter 0, will_detach 0, can_download 1, both stages empty.
// Stall: while i_out_stall holds a response, the next request waits in the
//   input register; a further request is stalled only once that is full.
module dfu_control_request_fsm #(
    parameter int BLOCK_COUNT_BITS = dfu_ctl_pkg::BLOCK_COUNT_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  dfu_ctl_pkg::t_req                      i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output dfu_ctl_pkg::t_resp                     o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dfu_ctl_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic                                   i_cfg_data
);

    logic              r_in_valid;
    dfu_ctl_pkg::t_req r_in_data;
    logic              r_out_valid;
    dfu_ctl_pkg::t_cfg r_cfg;
    logic              out_free;
    logic              step;
    logic              in_xfer;

    // handshake control
    assign out_free    = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    // hold the input transfer and the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data <= i_in_data;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.will_detach  <= 1'b0;
            r_cfg.can_download <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dfu_ctl_pkg::CFG_WILL_DETACH:  r_cfg.will_detach  <= i_cfg_data;
                dfu_ctl_pkg::CFG_CAN_DOWNLOAD: r_cfg.can_download <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    dfu_ctl_fsm #(
        .BLOCK_COUNT_BITS(BLOCK_COUNT_BITS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in_data),
        .i_cfg   (r_cfg),
        .o_resp  (o_out_data)
    );

`ifndef SYNTH
    // a held response is never overwritten
    a_no_step_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !step)
        else $error("response overwritten while stalled");

    // every decided request shows up as a response
    a_step_gives_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("decided request produced no response");

    // a block write is always acknowledged
    a_write_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.write_strobe) |->
        (o_out_data.resp_kind == dfu_ctl_pkg::RK_ACK))
        else $error("block write without acknowledge");

    // a write status only comes with a status report
    a_status_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status_code) |->
        (o_out_data.resp_kind == dfu_ctl_pkg::RK_STATUS))
        else $error("status code outside a status report");
`endif

endmodule

[tb/dfu_control_request_fsm_test.sv]
// Testbench for the DFU control request block: directed and random requests
// with an in-order response predictor. Depends on dfu_ctl_pkg, the RTL top.
`timescale 1ns / 100ps

module dfu_control_request_fsm_test;
    import dfu_ctl_pkg::*;

    // DFU state numbering as the block uses it
    typedef enum logic [3:0] {
        ST_APP_IDLE            = 4'd0,
        ST_APP_DETACH          = 4'd1,
        ST_DFU_IDLE            = 4'd2,
        ST_DNLOAD_SYNC         = 4'd3,
        ST_DNBUSY              = 4'd4,
        ST_DNLOAD_IDLE         = 4'd5,
        ST_MANIFEST_SYNC       = 4'd6,
        ST_MANIFEST            = 4'd7,
        ST_MANIFEST_WAIT_RESET = 4'd8,
        ST_UPLOAD_IDLE         = 4'd9,
        ST_ERROR               = 4'd10
    } t_dfu_state;

    localparam int RANDOM_REQS  = 750;
    localparam int PHASE_REQS   = 150;
    localparam int SETTLE_TICKS = 4;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_req                      i_in_data   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_resp                     o_out_data;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic                      i_cfg_data  = 1'b0;

    dfu_control_request_fsm dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the block state and registers
    t_dfu_state  mdl_state        = ST_APP_IDLE;
    logic        mdl_status       = STATUS_OK;
    logic [15:0] mdl_block        = '0;
    logic        mdl_will_detach  = 1'b0;
    logic        mdl_can_download = 1'b1;

    t_resp pending_resps[$];

    int err_count   = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_cfg       = 0;
    int n_detach    = 0;
    int n_wait_rst  = 0;

    // sender pacing
    int burst_left  = 0;
    bit gaps_on     = 1'b0;

    logic [7:0] known_cmds[6] = '{RQ_DETACH, RQ_DNLOAD, RQ_GETSTATUS,
                                  RQ_CLRSTATUS, RQ_GETSTATE, RQ_ABORT};

    function automatic t_resp status_resp();
        t_resp o;
        o              = '0;
        o.resp_kind    = RK_STATUS;
        o.status_code  = mdl_status;
        o.state_report = mdl_state;
        return o;
    endfunction

    function automatic t_resp state_resp();
        t_resp o;
        o              = '0;
        o.resp_kind    = RK_STATE;
        o.state_report = mdl_state;
        return o;
    endfunction

    function automatic t_resp stall_resp(input bit to_error);
        t_resp o;
        o           = '0;
        o.resp_kind = RK_STALL;
        if (to_error) begin
            mdl_state = ST_ERROR;
        end
        return o;
    endfunction

    // ack with a write of the current block, then advance the counter
    function automatic t_resp block_write_resp(input logic [15:0] len);
        t_resp o;
        o                    = '0;
        o.resp_kind          = RK_ACK;
        o.write_strobe       = 1'b1;
        o.write_block_number = mdl_block;
        o.write_length       = len;
        mdl_block            = mdl_block + 16'd1;
        mdl_state            = ST_DNLOAD_SYNC;
        return o;
    endfunction

    function automatic t_resp abort_resp();
        t_resp o;
        o             = '0;
        o.resp_kind   = RK_ACK;
        o.notify_kind = NT_ABORT;
        mdl_state     = ST_DFU_IDLE;
        mdl_block     = '0;
        return o;
    endfunction

    // media status seen by getstatus in a sync state; true when it is ok
    function automatic bit media_sync(input logic [1:0] media, input t_dfu_state ok_st,
                                      input t_dfu_state busy_st);
        case (media)
            MEDIA_OK: begin
                mdl_status = STATUS_OK;
                mdl_state  = ok_st;
                return 1'b1;
            end
            MEDIA_BUSY: begin
                mdl_status = STATUS_OK;
                mdl_state  = busy_st;
            end
            MEDIA_ERROR: begin
                mdl_status = STATUS_WRITE_ERR;
                mdl_state  = ST_ERROR;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // decide the response to one request and advance the DFU state
    function automatic t_resp dfu_response(input t_req r);
        t_resp o;
        bit    ok;
        o = '0;
        case (mdl_state)
            ST_APP_IDLE: begin
                if (r.cmd == RQ_DETACH) begin
                    o.resp_kind = RK_ACK;
                    if (mdl_will_detach) begin
                        o.event_detach = 1'b1;
                    end else begin
                        o.event_wait_reset = 1'b1;
                    end
                    mdl_state = ST_APP_DETACH;
                end else if (r.cmd == RQ_GETSTATUS) begin
                    o = status_resp();
                end else if (r.cmd == RQ_GETSTATE) begin
                    o = state_resp();
                end else begin
                    o = stall_resp(1'b0);
                end
            end
            ST_APP_DETACH: begin
                if (r.cmd == RQ_GETSTATUS) begin
                    o = status_resp();
                end else if (r.cmd == RQ_GETSTATE) begin
                    o = state_resp();
                end else begin
                    o = stall_resp(1'b0);
                end
            end
            ST_DFU_IDLE: begin
                if (r.cmd == RQ_DNLOAD) begin
                    if (r.req_length == 16'd0 || !mdl_can_download) begin
                        o = stall_resp(1'b1);
                    end else begin
                        o             = block_write_resp(r.req_length);
                        o.notify_kind = NT_BEGIN;
                    end
                end else if (r.cmd == RQ_ABORT) begin
                    o = abort_resp();
                end else if (r.cmd == RQ_GETSTATUS) begin
                    o = status_resp();
                end else if (r.cmd == RQ_GETSTATE) begin
                    o = state_resp();
                end else begin
                    o = stall_resp(1'b1);
                end
            end
            ST_DNLOAD_SYNC: begin
                if (r.cmd == RQ_GETSTATUS) begin
                    ok = media_sync(r.media_state, ST_DNLOAD_IDLE, ST_DNBUSY);
                    o  = status_resp();
                end else if (r.cmd == RQ_GETSTATE) begin
                    o = state_resp();
                end else begin
                    o = stall_resp(1'b1);
                end
            end
            ST_DNLOAD_IDLE: begin
                if (r.cmd == RQ_DNLOAD) begin
                    if (r.req_length == 16'd0) begin
                        o.resp_kind   = RK_ACK;
                        o.notify_kind = NT_END;
                        mdl_state     = ST_MANIFEST_SYNC;
                    end else begin
                        o = block_write_resp(r.req_length);
                    end
                end else if (r.cmd == RQ_ABORT) begin
                    o = abort_resp();
                end else if (r.cmd == RQ_GETSTATUS) begin
                    o = status_resp();
                end else if (r.cmd == RQ_GETSTATE) begin
                    o = state_resp();
                end else begin
                    o = stall_resp(1'b1);
                end
            end
            ST_MANIFEST_SYNC: begin
                if (r.cmd == RQ_GETSTATUS) begin
                    ok = media_sync(r.media_state, ST_MANIFEST_WAIT_RESET, ST_MANIFEST);
                    o  = status_resp();
                    o.event_detach = ok && mdl_will_detach;
                end else if (r.cmd == RQ_GETSTATE) begin
                    o = state_resp();
                end else begin
                    o = stall_resp(1'b0);
                end
            end
            ST_ERROR: begin
                // clear status goes back to idle but keeps the status bit
                if (r.cmd == RQ_CLRSTATUS) begin
                    o.resp_kind = RK_ACK;
                    mdl_state   = ST_DFU_IDLE;
                end else begin
                    o = stall_resp(1'b0);
                end
            end
            default: begin
                o.resp_kind = RK_UNKNOWN;
            end
        endcase
        return o;
    endfunction

    // insert a gap at the end of a burst when gaps are enabled
    task automatic pace_sender();
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // send one request, predict its response once the transfer happens
    task automatic send_req(input t_req r);
        t_resp exp_resp;
        i_in_data  <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        exp_resp = dfu_response(r);
        if (exp_resp.event_detach) n_detach++;
        if (exp_resp.event_wait_reset) n_wait_rst++;
        pending_resps.push_back(exp_resp);
        n_sent++;
        pace_sender();
    endtask

    task automatic send_fields(input logic [7:0] cmd, input logic [15:0] len,
                               input logic [1:0] media);
        t_req r;
        r.cmd         = cmd;
        r.req_length  = len;
        r.media_state = media;
        send_req(r);
    endtask

    // stop sending and let every outstanding response come back
    task automatic drain_responses();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_resps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_WILL_DETACH) begin
            mdl_will_detach = value;
        end else if (idx == CFG_CAN_DOWNLOAD) begin
            mdl_can_download = value;
        end
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_req random_req();
        t_req r;
        if ($urandom_range(0, 9) < 7) begin
            r.cmd = known_cmds[$urandom_range(0, 5)];
        end else begin
            r.cmd = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 3))
            0: r.req_length = 16'h0000;
            1: r.req_length = 16'hffff;
            2: r.req_length = 16'($urandom_range(1, 64));
            default: r.req_length = 16'($urandom);
        endcase
        r.media_state = 2'($urandom_range(0, 3));
        return r;
    endfunction

    // appIDLE: every request other than detach, with field extremes
    task automatic test_app_idle_requests();
        gaps_on = 1'b0;
        send_fields(RQ_GETSTATUS, 16'h0000, MEDIA_OK);
        send_fields(RQ_GETSTATE,  16'hffff, 2'd3);
        send_fields(RQ_DNLOAD,    16'h0001, MEDIA_BUSY);
        send_fields(RQ_DNLOAD,    16'h0000, MEDIA_ERROR);
        send_fields(RQ_CLRSTATUS, 16'h8000, MEDIA_OK);
        send_fields(RQ_ABORT,     16'h7fff, MEDIA_OK);
        send_fields(8'd2,         16'h0006, MEDIA_OK);
        send_fields(8'd7,         16'h0000, MEDIA_BUSY);
        send_fields(8'hff,        16'hffff, 2'd3);
        send_fields(8'h80,        16'h5555, MEDIA_ERROR);
        send_fields(RQ_GETSTATUS, 16'haaaa, 2'd3);
        drain_responses();
    endtask

    // configuration port, including indexes the block ignores
    task automatic test_config_port();
        cfg_write(CFG_CAN_DOWNLOAD, 1'b0);
        cfg_write(CFG_WILL_DETACH, 1'b1);
        cfg_write(8'd2, 1'b0);
        cfg_write(8'hff, 1'b1);
        cfg_write(CFG_CAN_DOWNLOAD, 1'b1);
        // the only detach accepted in the run picks self-detach or wait-reset per seed
        cfg_write(CFG_WILL_DETACH, 1'($urandom_range(0, 1)));
        send_fields(RQ_GETSTATE, 16'h0000, MEDIA_OK);
        drain_responses();
    endtask

    // detach leaves appIDLE; appDETACH accepts only the two queries
    task automatic test_detach();
        gaps_on = 1'b1;
        send_fields(RQ_DETACH,    16'h0000, MEDIA_OK);
        send_fields(RQ_GETSTATUS, 16'h0000, MEDIA_OK);
        send_fields(RQ_GETSTATE,  16'hffff, MEDIA_ERROR);
        send_fields(RQ_DETACH,    16'hffff, 2'd3);
        send_fields(RQ_DNLOAD,    16'h0040, MEDIA_OK);
        send_fields(RQ_CLRSTATUS, 16'h0000, MEDIA_BUSY);
        send_fields(RQ_ABORT,     16'h0000, MEDIA_OK);
        send_fields(8'h02,        16'h0001, MEDIA_OK);
        send_fields(8'hfe,        16'hfffe, 2'd3);
        drain_responses();
    endtask

    // random requests in phases, registers rewritten while idle in between
    task automatic test_random_requests();
        int phase_left;
        phase_left = PHASE_REQS;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i % 100 == 0) gaps_on = $urandom_range(0, 3) != 0;
            send_req(random_req());
            phase_left--;
            if (phase_left == 0) begin
                drain_responses();
                cfg_write(CFG_WILL_DETACH, 1'($urandom_range(0, 1)));
                cfg_write(CFG_CAN_DOWNLOAD, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1)) begin
                    cfg_write(CFG_INDEX_BITS'($urandom_range(2, 255)),
                              1'($urandom_range(0, 1)));
                end
                phase_left = PHASE_REQS;
            end
        end
        drain_responses();
    endtask

    // receiver stall pattern: free running, random, or long holds
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= $urandom_range(0, 2) == 0;
            default: begin
                if (hold_left == 0) begin
                    hold_left = $urandom_range(1, 15);
                    i_out_stall <= !i_out_stall;
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // compare each response transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_resp exp_resp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_resps.size() == 0) begin
                $error("response with no request outstanding: %h", o_out_data);
                err_count++;
            end else begin
                exp_resp = pending_resps.pop_front();
                check_field("resp_kind", exp_resp.resp_kind, o_out_data.resp_kind);
                check_field("status_code", exp_resp.status_code, o_out_data.status_code);
                check_field("state_report", exp_resp.state_report, o_out_data.state_report);
                check_field("event_detach", exp_resp.event_detach, o_out_data.event_detach);
                check_field("event_wait_reset", exp_resp.event_wait_reset,
                            o_out_data.event_wait_reset);
                check_field("notify_kind", exp_resp.notify_kind, o_out_data.notify_kind);
                check_field("write_strobe", exp_resp.write_strobe, o_out_data.write_strobe);
                check_field("write_block_number", exp_resp.write_block_number,
                            o_out_data.write_block_number);
                check_field("write_length", exp_resp.write_length, o_out_data.write_length);
                n_checked++;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_app_idle_requests();
        test_config_port();
        test_detach();
        test_random_requests();

        $display("covered %0d requests and %0d checked responses, %0d register writes",
                 n_sent, n_checked, n_cfg);
        $display("detach events: %0d self-detach, %0d wait-reset; final state %0d",
                 n_detach, n_wait_rst, mdl_state);
        if (err_count == 0) begin
            $display("dfu_control_request_fsm_test: done, clean");
        end else begin
            $display("dfu_control_request_fsm_test: done, errors");
        end
        $finish;
    end

    // hard stop if the handshakes hang
    initial begin
        #5000000;
        $display("timeout with %0d responses outstanding", pending_resps.size());
        $display("dfu_control_request_fsm_test: done, errors");
        $finish;
    end

endmodule

[files.f]
design/dfu_ctl_pkg.sv
design/dfu_ctl_fsm.sv
design/dfu_control_request_fsm.sv
tb/dfu_control_request_fsm_test.sv
